### hw/rtl/pdll_pkg.sv
// Shared types and codes for the pooled doubly linked list block.
package pdll_pkg;

  typedef logic [2:0] req_t;
  typedef logic [2:0] sel_t;
  typedef logic [1:0] cnt_op_t;
  typedef logic       cond_t;
  typedef logic [4:0] upc_t;
  typedef logic [1:0] status_t;

  // request codes
  localparam req_t REQ_INSERT = 3'd0;
  localparam req_t REQ_DELETE = 3'd1;
  localparam req_t REQ_NEXT   = 3'd2;
  localparam req_t REQ_PREV   = 3'd3;
  localparam req_t REQ_FETCH  = 3'd4;
  localparam req_t REQ_STORE  = 3'd5;

  // result status codes
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_TERM = 2'd2;

  // index source selects for addresses, write data, free head and result
  localparam sel_t SEL_POS  = 3'd0;
  localparam sel_t SEL_FH   = 3'd1;
  localparam sel_t SEL_NRD  = 3'd2;
  localparam sel_t SEL_PRD  = 3'd3;
  localparam sel_t SEL_TERM = 3'd4;

  localparam cnt_op_t CNT_HOLD = 2'd0;
  localparam cnt_op_t CNT_INC  = 2'd1;
  localparam cnt_op_t CNT_DEC  = 2'd2;

  localparam cond_t COND_FULL = 1'b0;
  localparam cond_t COND_TERM = 1'b1;

  // microcode addresses
  localparam upc_t U_IDLE = 5'd0;
  localparam upc_t U_INS0 = 5'd1;
  localparam upc_t U_INS1 = 5'd2;
  localparam upc_t U_INS2 = 5'd3;
  localparam upc_t U_INSF = 5'd4;
  localparam upc_t U_DEL0 = 5'd5;
  localparam upc_t U_DEL1 = 5'd6;
  localparam upc_t U_DEL2 = 5'd7;
  localparam upc_t U_DELT = 5'd8;
  localparam upc_t U_NXT0 = 5'd9;
  localparam upc_t U_NXT1 = 5'd10;
  localparam upc_t U_PRV0 = 5'd11;
  localparam upc_t U_PRV1 = 5'd12;
  localparam upc_t U_FET0 = 5'd13;
  localparam upc_t U_FET1 = 5'd14;
  localparam upc_t U_STO  = 5'd15;
  localparam upc_t U_NOP  = 5'd16;

  typedef struct packed {
    logic    n_re;
    sel_t    n_ra;
    logic    p_re;
    logic    d_re;
    logic    n_we;
    sel_t    n_wa;
    sel_t    n_wd;
    logic    p_we;
    sel_t    p_wa;
    sel_t    p_wd;
    logic    d_we;
    sel_t    d_wa;
    logic    fh_ld;
    sel_t    fh_src;
    cnt_op_t cnt_op;
    sel_t    res_src;
    logic    dout_en;
    status_t status;
    logic    last;
    logic    jmp;
    cond_t   cond;
    upc_t    target;
  } cw_t;

  typedef struct packed {
    logic full;
    logic term_pos;
  } flags_t;

endpackage

### hw/rtl/pdll_link_ram.sv
// Link memory with per-entry valid bits that stand in for the reset contents.
module pdll_link_ram #(
  parameter int DEPTH = 128,
  parameter bit CHAIN = 1'b1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   ra,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   wa,
  input  logic [$clog2(DEPTH)-1:0]   wd,
  output logic [$clog2(DEPTH)-1:0]   rd
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] TERM = AW'(DEPTH - 1);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [AW-1:0]    rd_raw;
  logic [AW-1:0]    rd_addr;
  logic             rd_vld;
  logic [AW-1:0]    rst_val;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_raw  <= mem[ra];
      rd_vld  <= vld[ra];
      rd_addr <= ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  // chained form: entry i links to i+1, the terminator to itself; unchained, every entry reads as the terminator
  always_comb begin
    if (CHAIN && rd_addr != TERM) begin
      rst_val = rd_addr + AW'(1);
    end else begin
      rst_val = TERM;
    end
  end

  assign rd = rd_vld ? rd_raw : rst_val;

endmodule

### hw/rtl/pdll_useq.sv
// Microcode sequencer: step counter, dispatch map and control word ROM.
module pdll_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pdll_pkg::req_t  req,
  input  pdll_pkg::flags_t flags,
  input  logic            go,
  output pdll_pkg::cw_t   cw,
  output logic            idle
);

  import pdll_pkg::*;

  upc_t upc;
  upc_t upc_next;
  logic hit;

  function automatic upc_t entry(input req_t r);
    upc_t e;
    begin
      unique case (r)
        REQ_INSERT: e = U_INS0;
        REQ_DELETE: e = U_DEL0;
        REQ_NEXT:   e = U_NXT0;
        REQ_PREV:   e = U_PRV0;
        REQ_FETCH:  e = U_FET0;
        REQ_STORE:  e = U_STO;
        default:    e = U_NOP;
      endcase
      return e;
    end
  endfunction

  function automatic cw_t rom(input upc_t a);
    cw_t w;
    begin
      w = '0;
      unique case (a)
        U_INS0: begin
          w.n_re = 1'b1; w.n_ra = SEL_FH; w.p_re = 1'b1;
          w.jmp = 1'b1; w.cond = COND_FULL; w.target = U_INSF;
        end
        U_INS1: begin
          w.n_we = 1'b1; w.n_wa = SEL_FH; w.n_wd = SEL_POS;
          w.p_we = 1'b1; w.p_wa = SEL_FH; w.p_wd = SEL_PRD;
          w.d_we = 1'b1; w.d_wa = SEL_FH;
        end
        U_INS2: begin
          w.n_we = 1'b1; w.n_wa = SEL_PRD; w.n_wd = SEL_FH;
          w.p_we = 1'b1; w.p_wa = SEL_POS; w.p_wd = SEL_FH;
          w.fh_ld = 1'b1; w.fh_src = SEL_NRD; w.cnt_op = CNT_INC;
          w.res_src = SEL_FH; w.last = 1'b1;
        end
        U_INSF: begin
          w.res_src = SEL_TERM; w.status = ST_FULL; w.last = 1'b1;
        end
        U_DEL0: begin
          w.n_re = 1'b1; w.n_ra = SEL_POS; w.p_re = 1'b1;
          w.jmp = 1'b1; w.cond = COND_TERM; w.target = U_DELT;
        end
        U_DEL1: begin
          w.n_we = 1'b1; w.n_wa = SEL_PRD; w.n_wd = SEL_NRD;
          w.p_we = 1'b1; w.p_wa = SEL_NRD; w.p_wd = SEL_PRD;
        end
        U_DEL2: begin
          w.n_we = 1'b1; w.n_wa = SEL_POS; w.n_wd = SEL_FH;
          w.p_we = 1'b1; w.p_wa = SEL_POS; w.p_wd = SEL_TERM;
          w.fh_ld = 1'b1; w.fh_src = SEL_POS; w.cnt_op = CNT_DEC;
          w.res_src = SEL_NRD; w.last = 1'b1;
        end
        U_DELT: begin
          w.res_src = SEL_TERM; w.status = ST_TERM; w.last = 1'b1;
        end
        U_NXT0: begin
          w.n_re = 1'b1; w.n_ra = SEL_POS;
        end
        U_NXT1: begin
          w.res_src = SEL_NRD; w.last = 1'b1;
        end
        U_PRV0: begin
          w.p_re = 1'b1;
        end
        U_PRV1: begin
          w.res_src = SEL_PRD; w.last = 1'b1;
        end
        U_FET0: begin
          w.d_re = 1'b1;
        end
        U_FET1: begin
          w.res_src = SEL_POS; w.dout_en = 1'b1; w.last = 1'b1;
        end
        U_STO: begin
          w.d_we = 1'b1; w.d_wa = SEL_POS; w.res_src = SEL_POS; w.last = 1'b1;
        end
        U_NOP: begin
          w.res_src = SEL_POS; w.last = 1'b1;
        end
        default: begin
          w = '0;
        end
      endcase
      return w;
    end
  endfunction

  assign cw   = rom(upc);
  assign idle = (upc == U_IDLE);
  assign hit  = (cw.cond == COND_FULL) ? flags.full : flags.term_pos;

  always_comb begin
    if (start) begin
      upc_next = entry(req);
    end else if (idle || !go) begin
      upc_next = upc;
    end else if (cw.last) begin
      upc_next = U_IDLE;
    end else if (cw.jmp && hit) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

### hw/rtl/pooled_doubly_linked_list_top.sv
// Top level: datapath, payload memory and free head around the microcode sequencer.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | req_type, position_index, data_in
//   out     | output    | out_valid/out_stall | result_index, data_out, status,
//           |           |                     | element_count, is_empty
//
// Each request code, refused requests included, runs its own microprogram, whose
// length sets how long the request takes, with link memory reads registered
// one step ahead of the writes that use them.
// A new request is taken in the last step of the previous one.
// Reset is immediate: link memories carry per-entry valid bits, no clearing pass.
// A stalled output holds the last step until the result register drains.
module pooled_doubly_linked_list_top #(
  parameter int POOL_DEPTH = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [$clog2(POOL_DEPTH)-1:0] position_index,
  input  logic [DATA_WIDTH-1:0]         data_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [$clog2(POOL_DEPTH)-1:0] result_index,
  output logic [DATA_WIDTH-1:0]         data_out,
  output logic [1:0]                    status,
  output logic [$clog2(POOL_DEPTH)-1:0] element_count,
  output logic                          is_empty
);

  import pdll_pkg::*;

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam logic [IDX_W-1:0] TERM    = IDX_W'(POOL_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(POOL_DEPTH);
  localparam logic [IDX_W-1:0] ONE_CNT = IDX_W'(1);

  cw_t    cw;
  flags_t flags;
  logic   idle;
  logic   go;
  logic   accept;

  logic [IDX_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] din_r;
  logic [IDX_W-1:0]      fh;
  logic [IDX_W-1:0]      cnt;
  logic [IDX_W-1:0]      cnt_next;
  logic [IDX_W:0]        pos_ext;
  logic [IDX_W-1:0]      pos_in;

  logic [IDX_W-1:0] n_rd;
  logic [IDX_W-1:0] p_rd;
  logic [IDX_W-1:0] n_ra;
  logic [IDX_W-1:0] n_wa;
  logic [IDX_W-1:0] n_wd;
  logic [IDX_W-1:0] p_wa;
  logic [IDX_W-1:0] p_wd;
  logic [IDX_W-1:0] d_wa;
  logic [IDX_W-1:0] fh_val;
  logic [IDX_W-1:0] res_val;

  logic [DATA_WIDTH-1:0] payload_mem [POOL_DEPTH];
  logic [DATA_WIDTH-1:0] d_rd;

  function automatic logic [IDX_W-1:0] pick(
    input sel_t             s,
    input logic [IDX_W-1:0] a_pos,
    input logic [IDX_W-1:0] a_fh,
    input logic [IDX_W-1:0] a_nrd,
    input logic [IDX_W-1:0] a_prd
  );
    logic [IDX_W-1:0] v;
    begin
      case (s)
        SEL_FH:   v = a_fh;
        SEL_NRD:  v = a_nrd;
        SEL_PRD:  v = a_prd;
        SEL_TERM: v = TERM;
        default:  v = a_pos;
      endcase
      return v;
    end
  endfunction

  // last step waits while the result register is still full
  assign go       = !(cw.last && out_valid && out_stall);
  assign in_stall = !(idle || (cw.last && go));
  assign accept   = in_valid && !in_stall;

  // position reduced into the pool; the port value stays below twice the depth
  assign pos_ext = {1'b0, position_index};
  assign pos_in  = (pos_ext >= DEPTH_X) ? IDX_W'(pos_ext - DEPTH_X) : position_index;

  assign flags.full     = (fh == TERM);
  assign flags.term_pos = (pos_r == TERM);

  assign n_ra    = pick(cw.n_ra,    pos_r, fh, n_rd, p_rd);
  assign n_wa    = pick(cw.n_wa,    pos_r, fh, n_rd, p_rd);
  assign n_wd    = pick(cw.n_wd,    pos_r, fh, n_rd, p_rd);
  assign p_wa    = pick(cw.p_wa,    pos_r, fh, n_rd, p_rd);
  assign p_wd    = pick(cw.p_wd,    pos_r, fh, n_rd, p_rd);
  assign d_wa    = pick(cw.d_wa,    pos_r, fh, n_rd, p_rd);
  assign fh_val  = pick(cw.fh_src,  pos_r, fh, n_rd, p_rd);
  assign res_val = pick(cw.res_src, pos_r, fh, n_rd, p_rd);

  always_comb begin
    cnt_next = cnt;
    if (go) begin
      case (cw.cnt_op)
        CNT_INC: cnt_next = cnt + ONE_CNT;
        CNT_DEC: cnt_next = cnt - ONE_CNT;
        default: cnt_next = cnt;
      endcase
    end
  end

  pdll_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .req   (req_type),
    .flags (flags),
    .go    (go),
    .cw    (cw),
    .idle  (idle)
  );

  pdll_link_ram #(
    .DEPTH (POOL_DEPTH),
    .CHAIN (1'b1)
  ) u_next (
    .clk (clk),
    .rst (rst),
    .re  (cw.n_re && go),
    .ra  (n_ra),
    .we  (cw.n_we && go),
    .wa  (n_wa),
    .wd  (n_wd),
    .rd  (n_rd)
  );

  pdll_link_ram #(
    .DEPTH (POOL_DEPTH),
    .CHAIN (1'b0)
  ) u_prev (
    .clk (clk),
    .rst (rst),
    .re  (cw.p_re && go),
    .ra  (pos_r),
    .we  (cw.p_we && go),
    .wa  (p_wa),
    .wd  (p_wd),
    .rd  (p_rd)
  );

  always_ff @(posedge clk) begin
    if (cw.d_we && go) begin
      payload_mem[d_wa] <= din_r;
    end
    if (cw.d_re && go) begin
      d_rd <= payload_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r <= pos_in;
      din_r <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fh  <= '0;
      cnt <= '0;
    end else begin
      if (cw.fh_ld && go) begin
        fh <= fh_val;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.last && go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.last && go) begin
      result_index  <= res_val;
      data_out      <= cw.dout_en ? d_rd : '0;
      status        <= cw.status;
      element_count <= cnt_next;
      is_empty      <= (cnt_next == '0);
    end
  end

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cw.last && go && !accept) |=> idle)
    else $error("sequencer did not return to idle after the last step");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt == $past(cnt) || cnt == $past(cnt) + ONE_CNT ||
                     cnt == $past(cnt) - ONE_CNT))
    else $error("element count moved by more than one");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (cw.last && go && cw.status == ST_FULL) |-> (fh == TERM))
    else $error("insert refused while free entries remain");

  a_term_refusal: assert property (@(posedge clk) disable iff (rst)
    (cw.last && go && cw.status == ST_TERM) |-> (pos_r == TERM && cw.cnt_op == CNT_HOLD))
    else $error("delete refused for a node other than the terminator");

endmodule
